// File: design/alnd_pkg.sv
// Shared types and constants for the airborne/landing detector.
// Used by alnd_ctrl, alnd_dp and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alnd_pkg;

   // field and port widths
   localparam int unsigned TS_W       = 32;
   localparam int unsigned ACC_W      = 16;
   localparam int unsigned MAG2_W     = 32;
   localparam int unsigned SCALE_W    = 16;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 15;
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned RAMP_W     = 11;

   // sequencing
   localparam int unsigned MUL_STEPS  = 6;
   localparam int unsigned DIV_STEPS  = 15;
   localparam int unsigned CNT_W      = 4;

   localparam int unsigned CONFIRM_MS_DEFAULT = 30;

   // detector modes
   localparam logic [CODE_W-1:0] MODE_GROUNDED   = 3'd0;
   localparam logic [CODE_W-1:0] MODE_AIRBORNE   = 3'd1;
   localparam logic [CODE_W-1:0] MODE_SETTLING   = 3'd2;
   localparam logic [CODE_W-1:0] MODE_RECOVERING = 3'd3;
   localparam logic [CODE_W-1:0] MODE_FAULT      = 3'd4;

   // events
   localparam logic [CODE_W-1:0] EV_NONE          = 3'd0;
   localparam logic [CODE_W-1:0] EV_AIRBORNE      = 3'd1;
   localparam logic [CODE_W-1:0] EV_FAULT         = 3'd2;
   localparam logic [CODE_W-1:0] EV_RESET_ATT     = 3'd3;
   localparam logic [CODE_W-1:0] EV_RECOVERY_DONE = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_ENABLE     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_AIR_THR    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_AIR    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_LAND_MIN   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LAND_MAX   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_SETTLE     = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_LAND_TMO   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_RAMP       = 3'd7;

   // register ranges and reset values
   localparam logic [15:0] AIR_THR_LO  = 16'd205;
   localparam logic [15:0] AIR_THR_HI  = 16'd3891;
   localparam logic [15:0] AIR_THR_RST = 16'd1434;
   localparam logic [15:0] MAX_AIR_LO  = 16'd100;
   localparam logic [15:0] MAX_AIR_HI  = 16'd2000;
   localparam logic [15:0] MAX_AIR_RST = 16'd800;
   localparam logic [15:0] LAND_MIN_LO  = 16'd410;
   localparam logic [15:0] LAND_MIN_HI  = 16'd14336;
   localparam logic [15:0] LAND_MIN_RST = 16'd3277;
   localparam logic [15:0] LAND_MAX_LO  = 16'd819;
   localparam logic [15:0] LAND_MAX_HI  = 16'd16384;
   localparam logic [15:0] LAND_MAX_RST = 16'd10240;
   localparam logic [15:0] SETTLE_LO  = 16'd10;
   localparam logic [15:0] SETTLE_HI  = 16'd500;
   localparam logic [15:0] SETTLE_RST = 16'd50;
   localparam logic [15:0] LAND_TMO_LO  = 16'd100;
   localparam logic [15:0] LAND_TMO_HI  = 16'd3000;
   localparam logic [15:0] LAND_TMO_RST = 16'd1000;
   localparam logic [15:0] RAMP_LO  = 16'd0;
   localparam logic [15:0] RAMP_HI  = 16'd1500;
   localparam logic [15:0] RAMP_RST = 16'd300;

   localparam logic [SCALE_W-1:0] Q15_ONE = 16'h8000;

   // multiplier operand selects
   localparam logic [2:0] SEL_X   = 3'd0;
   localparam logic [2:0] SEL_Y   = 3'd1;
   localparam logic [2:0] SEL_Z   = 3'd2;
   localparam logic [2:0] SEL_THR = 3'd3;
   localparam logic [2:0] SEL_LO  = 3'd4;
   localparam logic [2:0] SEL_HI  = 3'd5;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [2:0] mul_sel;
      logic       diff;
      logic       update;
      logic       elapsed;
      logic       div_init;
      logic       div_step;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic active;
      logic div_needed;
   } status_type;

endpackage

`default_nettype wire

// File: design/alnd_ctrl.sv
// Sequencer for the airborne/landing detector: steps the shared multiplier,
// the update and the Q15 divider, and owns the result handshake. Uses alnd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alnd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire alnd_pkg::status_type status,
   output alnd_pkg::cmd_type        cmd
);
   import alnd_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_MUL     = 8'b0000_0010,
      S_DIFF    = 8'b0000_0100,
      S_UPDATE  = 8'b0000_1000,
      S_ELAPSED = 8'b0001_0000,
      S_SCALE   = 8'b0010_0000,
      S_DIV     = 8'b0100_0000,
      S_EMIT    = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      cmd.mul_sel  = cnt_ff[2:0];
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!status.active) begin
               state_in = S_ELAPSED;
            end else begin
               cmd.mul_en = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_ELAPSED;
         end
         S_ELAPSED: begin
            cmd.elapsed = 1'b1;
            state_in    = S_SCALE;
         end
         S_SCALE: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = status.div_needed ? S_DIV : S_EMIT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // wait until the output register is free or being taken
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/alnd_dp.sv
// Datapath of the airborne/landing detector: configuration registers,
// detector state, shared squarer, timestamp differences and the Q15 divider.
// Uses alnd_pkg; driven by alnd_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module alnd_dp #(
   parameter int unsigned CONFIRM_MS = alnd_pkg::CONFIRM_MS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire alnd_pkg::cmd_type                   cmd,
   output alnd_pkg::status_type                     status,
   input  wire logic [alnd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                req_tuser,
   input  wire logic                                csr_we,
   input  wire logic [alnd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [alnd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [alnd_pkg::RSP_DATA_W-1:0]          rsp_tdata
);
   import alnd_pkg::*;

   localparam logic [TS_W-1:0] CONFIRM_TS = TS_W'(CONFIRM_MS);

   function automatic logic [15:0] clamp16(input logic [15:0] v,
                                           input logic [15:0] lo,
                                           input logic [15:0] hi);
      logic [15:0] r;
      r = v;
      if (v < lo) r = lo;
      if (v > hi) r = hi;
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] abs16(input logic [ACC_W-1:0] m);
      return m[ACC_W-1] ? (~m + 1'b1) : m;
   endfunction

   // configuration
   logic                enable_ff;
   logic [11:0]         air_thr_ff;
   logic [10:0]         max_air_ff;
   logic [13:0]         land_min_ff;
   logic [14:0]         land_max_ff;
   logic [8:0]          settle_ff;
   logic [11:0]         land_tmo_ff;
   logic [RAMP_W-1:0]   ramp_ff;

   // detector state
   logic [CODE_W-1:0]   mode_ff, mode_in;
   logic [TS_W-1:0]     low_since_ff, low_since_in;
   logic [TS_W-1:0]     air_since_ff, air_since_in;
   logic [TS_W-1:0]     land_since_ff, land_since_in;
   logic [TS_W-1:0]     stable_since_ff, stable_since_in;
   logic [TS_W-1:0]     rec_since_ff, rec_since_in;
   logic [CODE_W-1:0]   ev_ff, ev_in;

   // captured item
   logic                valid_ff;
   logic [ACC_W-1:0]    ax_ff, ay_ff, az_ff;
   logic [TS_W-1:0]     now_ff;

   // squares
   logic [ACC_W-1:0]    mul_op;
   logic [MAG2_W-1:0]   prod_ff;
   logic [2:0]          prod_sel_ff;
   logic                prod_vld_ff;
   logic [MAG2_W-1:0]   mag2_ff;
   logic [23:0]         thr2_ff;
   logic [29:0]         lo2_ff, hi2_ff;
   logic [14:0]         land_min_ext, band_lo, band_hi;

   // time differences and divider
   logic [TS_W-1:0]     low_eff, stamp_a, diff_a_ff, diff_b_ff, elapsed_ff;
   logic [RAMP_W-1:0]   rem_ff;
   logic [RAMP_W:0]     rem2;
   logic [DIV_STEPS-1:0] quo_ff;
   logic                low_acc, above_lo, in_band;
   logic [SCALE_W-1:0]  scale;
   logic                use_corr, hold_motor, allow_motion;

   assign land_min_ext = {1'b0, land_min_ff};
   assign band_lo = (land_min_ext < land_max_ff) ? land_min_ext : land_max_ff;
   assign band_hi = (land_min_ext > land_max_ff) ? land_min_ext : land_max_ff;

   assign status.active     = enable_ff & valid_ff;
   assign status.div_needed = (mode_ff == MODE_RECOVERING) && (ramp_ff != '0)
                              && (elapsed_ff < TS_W'(ramp_ff));

   always_comb begin
      case (cmd.mul_sel)
         SEL_X:   mul_op = abs16(ax_ff);
         SEL_Y:   mul_op = abs16(ay_ff);
         SEL_Z:   mul_op = abs16(az_ff);
         SEL_THR: mul_op = ACC_W'(air_thr_ff);
         SEL_LO:  mul_op = ACC_W'(band_lo);
         SEL_HI:  mul_op = ACC_W'(band_hi);
         default: mul_op = '0;
      endcase
   end

   // a zero stamp means the wait has not started: it starts now
   assign low_eff = (low_since_ff == '0) ? now_ff : low_since_ff;

   always_comb begin
      case (mode_ff)
         MODE_GROUNDED:   stamp_a = low_eff;
         MODE_AIRBORNE:   stamp_a = air_since_ff;
         MODE_SETTLING:   stamp_a = land_since_ff;
         MODE_RECOVERING: stamp_a = rec_since_ff;
         default:         stamp_a = now_ff;
      endcase
   end

   assign low_acc  = mag2_ff < MAG2_W'(thr2_ff);
   assign above_lo = mag2_ff >= MAG2_W'(lo2_ff);
   assign in_band  = above_lo && (mag2_ff <= MAG2_W'(hi2_ff));

   always_comb begin
      mode_in         = mode_ff;
      low_since_in    = low_since_ff;
      air_since_in    = air_since_ff;
      land_since_in   = land_since_ff;
      stable_since_in = stable_since_ff;
      rec_since_in    = rec_since_ff;
      ev_in           = EV_NONE;
      unique case (mode_ff)
         MODE_GROUNDED: begin
            if (low_acc) begin
               low_since_in = low_eff;
               if (diff_a_ff >= CONFIRM_TS) begin
                  mode_in      = MODE_AIRBORNE;
                  air_since_in = now_ff;
                  low_since_in = '0;
                  ev_in        = EV_AIRBORNE;
               end
            end else begin
               low_since_in = '0;
            end
         end
         MODE_AIRBORNE: begin
            if (diff_a_ff > TS_W'(max_air_ff)) begin
               mode_in = MODE_FAULT;
               ev_in   = EV_FAULT;
            end else if (above_lo) begin
               mode_in         = MODE_SETTLING;
               land_since_in   = now_ff;
               stable_since_in = in_band ? now_ff : '0;
            end
         end
         MODE_SETTLING: begin
            if (diff_a_ff > TS_W'(land_tmo_ff)) begin
               mode_in = MODE_FAULT;
               ev_in   = EV_FAULT;
            end else if (!in_band) begin
               stable_since_in = '0;
            end else if (stable_since_ff == '0) begin
               stable_since_in = now_ff;
            end else if (diff_b_ff >= TS_W'(settle_ff)) begin
               mode_in      = MODE_RECOVERING;
               rec_since_in = now_ff;
               ev_in        = EV_RESET_ATT;
            end
         end
         MODE_RECOVERING: begin
            if (diff_a_ff >= TS_W'(ramp_ff)) begin
               mode_in = MODE_GROUNDED;
               ev_in   = EV_RECOVERY_DONE;
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // configuration and detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff       <= 1'b0;
         air_thr_ff      <= 12'(AIR_THR_RST);
         max_air_ff      <= 11'(MAX_AIR_RST);
         land_min_ff     <= 14'(LAND_MIN_RST);
         land_max_ff     <= 15'(LAND_MAX_RST);
         settle_ff       <= 9'(SETTLE_RST);
         land_tmo_ff     <= 12'(LAND_TMO_RST);
         ramp_ff         <= RAMP_W'(RAMP_RST);
         mode_ff         <= MODE_GROUNDED;
         low_since_ff    <= '0;
         air_since_ff    <= '0;
         land_since_ff   <= '0;
         stable_since_ff <= '0;
         rec_since_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ENABLE: begin
               // any write here restarts the detector
               enable_ff       <= csr_wdata[0];
               mode_ff         <= MODE_GROUNDED;
               low_since_ff    <= '0;
               air_since_ff    <= '0;
               land_since_ff   <= '0;
               stable_since_ff <= '0;
               rec_since_ff    <= '0;
            end
            REG_AIR_THR:  air_thr_ff  <= 12'(clamp16(16'(csr_wdata[11:0]),
                                                     AIR_THR_LO, AIR_THR_HI));
            REG_MAX_AIR:  max_air_ff  <= 11'(clamp16(16'(csr_wdata[10:0]),
                                                     MAX_AIR_LO, MAX_AIR_HI));
            REG_LAND_MIN: land_min_ff <= 14'(clamp16(16'(csr_wdata[13:0]),
                                                     LAND_MIN_LO, LAND_MIN_HI));
            REG_LAND_MAX: land_max_ff <= 15'(clamp16(16'(csr_wdata[14:0]),
                                                     LAND_MAX_LO, LAND_MAX_HI));
            REG_SETTLE:   settle_ff   <= 9'(clamp16(16'(csr_wdata[8:0]),
                                                    SETTLE_LO, SETTLE_HI));
            REG_LAND_TMO: land_tmo_ff <= 12'(clamp16(16'(csr_wdata[11:0]),
                                                     LAND_TMO_LO, LAND_TMO_HI));
            REG_RAMP:     ramp_ff     <= RAMP_W'(clamp16(16'(csr_wdata[10:0]),
                                                         RAMP_LO, RAMP_HI));
            default:      ramp_ff     <= ramp_ff;
         endcase
      end else if (cmd.update && status.active) begin
         mode_ff         <= mode_in;
         low_since_ff    <= low_since_in;
         air_since_ff    <= air_since_in;
         land_since_ff   <= land_since_in;
         stable_since_ff <= stable_since_in;
         rec_since_ff    <= rec_since_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         valid_ff <= req_tuser;
         ax_ff    <= req_tdata[15:0];
         ay_ff    <= req_tdata[31:16];
         az_ff    <= req_tdata[47:32];
         now_ff   <= req_tdata[79:48];
         ev_ff    <= EV_NONE;
      end
      if (cmd.update && status.active) begin
         ev_ff <= ev_in;
      end
      prod_ff     <= MAG2_W'(mul_op) * MAG2_W'(mul_op);
      prod_sel_ff <= cmd.mul_sel;
      if (prod_vld_ff) begin
         case (prod_sel_ff)
            SEL_X:   mag2_ff <= prod_ff;
            SEL_Y:   mag2_ff <= mag2_ff + prod_ff;
            SEL_Z:   mag2_ff <= mag2_ff + prod_ff;
            SEL_THR: thr2_ff <= prod_ff[23:0];
            SEL_LO:  lo2_ff  <= prod_ff[29:0];
            SEL_HI:  hi2_ff  <= prod_ff[29:0];
            default: mag2_ff <= mag2_ff;
         endcase
      end
      if (cmd.diff) begin
         diff_a_ff <= now_ff - stamp_a;
         diff_b_ff <= now_ff - stable_since_ff;
      end
      if (cmd.elapsed) begin
         elapsed_ff <= now_ff - rec_since_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= elapsed_ff[RAMP_W-1:0];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         // one quotient bit per step: remainder doubles and compares
         if (rem2 >= {1'b0, ramp_ff}) begin
            rem_ff <= RAMP_W'(rem2 - {1'b0, ramp_ff});
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff <= rem2[RAMP_W-1:0];
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
      if (cmd.emit) begin
         rsp_tdata <= {7'b0, scale, allow_motion, hold_motor, use_corr, mode_ff, ev_ff};
      end
   end

   assign rem2 = {rem_ff, 1'b0};

   assign use_corr     = (mode_ff == MODE_GROUNDED) || (mode_ff == MODE_RECOVERING);
   assign hold_motor   = (mode_ff == MODE_AIRBORNE) || (mode_ff == MODE_SETTLING)
                         || (mode_ff == MODE_FAULT);
   assign allow_motion = (mode_ff == MODE_GROUNDED);

   always_comb begin
      if (mode_ff == MODE_GROUNDED) begin
         scale = Q15_ONE;
      end else if (mode_ff != MODE_RECOVERING || ramp_ff == '0) begin
         scale = '0;
      end else if (elapsed_ff >= TS_W'(ramp_ff)) begin
         scale = Q15_ONE;
      end else begin
         scale = {1'b0, quo_ff};
      end
   end

endmodule

`default_nettype wire

// File: design/airborne_landing_detector.sv
// Airborne/landing detector top level: joins alnd_ctrl and alnd_dp.
// Depends on alnd_pkg, alnd_ctrl and alnd_dp.
//
// One accelerometer item is worked at a time. A valid item with the detector
// enabled passes six times through the single shared 16x16 squarer (three
// axes and three thresholds), then the timestamp differences, the state
// update, the recovery time, the bit-serial Q15 motor scale division and
// the loading of the result, which waits while the output register is full
// and not being taken. The divider runs only while recovering with the ramp
// still in progress; otherwise it is skipped. When the detector is disabled
// or the sample flag is low the squarer, differences and update are skipped,
// but a held recovery may still need the divider. A finished result sits in
// the output register while the next item is taken in. Configuration writes
// belong in idle periods; a write to enable restarts the detector grounded.
`timescale 1ns / 1ps
`default_nettype none

module airborne_landing_detector #(
   parameter int unsigned CONFIRM_MS = alnd_pkg::CONFIRM_MS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // accel_x [15:0], accel_y [31:16], accel_z [47:32], now_ms [79:48]
   input  wire logic [alnd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // sample_valid
   input  wire logic                               req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // event_res [2:0], mode [5:3], use_accel_correction [6], hold_motor [7],
   // allow_motion [8], motor_scale [24:9], zero [31:25]
   output logic [alnd_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [alnd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [alnd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import alnd_pkg::*;

   cmd_type    cmd;
   status_type status;

   alnd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   alnd_dp #(
      .CONFIRM_MS (CONFIRM_MS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
